[design/lpcp_pkg.sv]
// Shared constants, codes and types of the lidar point camera projection block.
package lpcp_pkg;

	localparam int IMAGE_WIDTH  = 640;
	localparam int IMAGE_HEIGHT = 480;

	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int LEVEL_W = 8;

	// Quotient bits produced by the divider pipelines; also its stage count.
	localparam int QS_WH = ($clog2(IMAGE_WIDTH) > $clog2(IMAGE_HEIGHT)) ?
		$clog2(IMAGE_WIDTH) : $clog2(IMAGE_HEIGHT);
	localparam int QS = (QS_WH > COL_W) ? QS_WH : COL_W;

	// Width of projected numerators and depths after sign folding.
	localparam int DIV_W = 51;

	localparam int CFG_IDX_W = 4;

	localparam logic [31:0] Q_HUNDRED     = 32'd6553600;
	localparam logic [31:0] MIN_RANGE_RST = 32'd7;
	localparam logic [31:0] MAX_RANGE_RST = 32'd13107200;

	// Division by 100 as a reciprocal multiply: floor(m / 100) equals
	// (m * 5243) >> 19 for every m below 43690.
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_COLS01 = 4'd0,
		REG_ROW0_COLS23 = 4'd1,
		REG_ROW1_COLS01 = 4'd2,
		REG_ROW1_COLS23 = 4'd3,
		REG_ROW2_COLS01 = 4'd4,
		REG_ROW2_COLS23 = 4'd5,
		REG_MIN_RANGE   = 4'd6,
		REG_MAX_RANGE   = 4'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		V_KEPT  = 2'd0,
		V_FOV   = 2'd1,
		V_RANGE = 2'd2,
		V_IMAGE = 2'd3
	} verdict_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] red;
	} side_t;

endpackage

[design/lpcp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module lpcp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [lpcp_pkg::DIV_W-1:0]    num,
	input  logic [lpcp_pkg::DIV_W-1:0]    den,
	output logic [lpcp_pkg::QS-1:0]       quo
);

	localparam int W  = lpcp_pkg::DIV_W;
	localparam int QN = lpcp_pkg::QS;

	logic [W-1:0]  rem_s [QN-1];
	logic [W-1:0]  den_s [QN-1];
	logic [QN-1:0] quo_s [QN];

	// The caller guarantees num < den * 2^QS whenever the quotient is used.
	for (genvar k = 0; k < QN; k++) begin : g_stage
		logic [W-1:0]    rem_in;
		logic [W-1:0]    den_in;
		logic [QN-1:0]   quo_in;
		logic [W+QN-1:0] trial;
		logic            fits;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = {{QN{1'b0}}, den_in} << (QN - 1 - k);
		assign fits  = ({{QN{1'b0}}, rem_in} >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_in | (fits ? (QN'(1) << (QN - 1 - k)) : '0);
			end
		end

		if (k < QN - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fits ? (rem_in - trial[W-1:0]) : rem_in;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = quo_s[QN-1];

endmodule

[design/lidar_point_camera_projection.sv]
// Top level: lidar point culling and pinhole projection to camera pixels.
//
// Usage. Points enter on the s_axis channel (x, y, z in signed Q15.16 metres)
// and leave on the m_axis channel, exactly one result per point, in order.
// Each result carries a verdict in tuser (kept, outside field of view, outside
// range, outside image) and, for a kept point, the pixel column and row and
// the green and red levels in tdata; all tdata fields are zero otherwise.
// The cfg channel writes the 3x4 projection matrix and the range bounds; it
// is always ready and should only be used while no point is in flight.
// Writes to indexes past the last register are ignored.
// The pipeline is one multiply stage, one summing stage, one sign folding
// stage, then one stage per quotient bit of the divider pipelines that give
// column and row. The color levels are finished by a reciprocal multiply
// and wait beside the dividers. Every stage advances together.
// Throughput is one point per cycle while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// s_axis_tready drops, so no transfer is lost or repeated.
// Reset clears all valid bits and loads the register reset values: zero
// matrix, minimum range 7 (Q16.16) and maximum range 200 m.
module lidar_point_camera_projection (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [95:0]                      s_axis_tdata,  // point_x, point_y, point_z
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [39:0]                      m_axis_tdata,  // pixel_column, pixel_row,
	                                                        // green_level, red_level, zero pad
	output logic [1:0]                       m_axis_tuser,  // verdict
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpcp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                      cfg_data
);

	localparam int QN = lpcp_pkg::QS;
	localparam int W  = lpcp_pkg::DIV_W;

	// Configuration registers.
	logic [63:0] coef_q [6];
	logic [31:0] min_q;
	logic [31:0] max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				coef_q[i] <= '0;
			end
			min_q <= lpcp_pkg::MIN_RANGE_RST;
			max_q <= lpcp_pkg::MAX_RANGE_RST;
		end else if (cfg_valid) begin
			case (lpcp_pkg::reg_idx_t'(cfg_index))
				lpcp_pkg::REG_ROW0_COLS01: coef_q[0] <= cfg_data;
				lpcp_pkg::REG_ROW0_COLS23: coef_q[1] <= cfg_data;
				lpcp_pkg::REG_ROW1_COLS01: coef_q[2] <= cfg_data;
				lpcp_pkg::REG_ROW1_COLS23: coef_q[3] <= cfg_data;
				lpcp_pkg::REG_ROW2_COLS01: coef_q[4] <= cfg_data;
				lpcp_pkg::REG_ROW2_COLS23: coef_q[5] <= cfg_data;
				lpcp_pkg::REG_MIN_RANGE:   min_q     <= cfg_data[31:0];
				lpcp_pkg::REG_MAX_RANGE:   max_q     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Pipeline advance: everything moves unless a finished result is stalled.
	logic en;
	logic vld_s1, vld_s2, vld_s3;
	logic [QN-1:0] vld_s4;
	lpcp_pkg::side_t side_s4 [QN];

	assign en            = !vld_s4[QN-1] || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: all products and the field of view test.
	logic signed [31:0] pin_x, pin_y, pin_z;
	logic        [31:0] ax, ay, az;

	assign pin_x = s_axis_tdata[31:0];
	assign pin_y = s_axis_tdata[63:32];
	assign pin_z = s_axis_tdata[95:64];
	assign ax    = pin_x[31] ? 32'(-pin_x) : pin_x;
	assign ay    = pin_y[31] ? 32'(-pin_y) : pin_y;
	assign az    = pin_z[31] ? 32'(-pin_z) : pin_z;

	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] off_s1 [3];
	logic        [63:0] sqx_s1, sqy_s1, sqz_s1, mn_s1, mx_s1;
	logic               fov_s1;
	logic signed [31:0] x_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= $signed(coef_q[2*r][31:0])    * pin_x;
				prod_s1[r][1] <= $signed(coef_q[2*r][63:32])   * pin_y;
				prod_s1[r][2] <= $signed(coef_q[2*r+1][31:0])  * pin_z;
				off_s1[r]     <= $signed(coef_q[2*r+1][63:32]);
			end
			sqx_s1 <= ax * ax;
			sqy_s1 <= ay * ay;
			sqz_s1 <= az * az;
			mn_s1  <= min_q * min_q;
			mx_s1  <= max_q * max_q;
			fov_s1 <= ($signed({pin_x[31], pin_x}) < $signed({1'b0, ay}));
			x_s1   <= pin_x;
		end
	end

	// Stage 2: projected rows (floor of each Q.16 product), squared distance.
	logic signed [W-1:0] n_s2 [3];
	logic        [63:0]  d2_s2, mn_s2, mx_s2;
	logic                fov_s2;
	logic        [32:0]  diff_s2;
	logic signed [32:0]  xm;

	assign xm = {x_s1[31], x_s1} - $signed({1'b0, lpcp_pkg::Q_HUNDRED});

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				n_s2[r] <= W'(prod_s1[r][0] >>> 16) + W'(prod_s1[r][1] >>> 16)
					+ W'(prod_s1[r][2] >>> 16)
					+ {{(W-32){off_s1[r][31]}}, off_s1[r]};
			end
			d2_s2   <= sqx_s1 + sqy_s1 + sqz_s1;
			mn_s2   <= mn_s1;
			mx_s2   <= mx_s1;
			fov_s2  <= fov_s1;
			diff_s2 <= xm[32] ? 33'(-xm) : xm;
		end
	end

	// Stage 3: fold the sign of the depth into the numerators, range test,
	// color numerators.
	logic signed [W-1:0] n0_s3, n1_s3;
	logic        [W-1:0] den_s3;
	logic                zero_s3, range_s3, fov_s3, gsat_s3;
	logic        [40:0]  numg_s3, numr_s3;
	logic        [40:0]  numg;
	logic        [32:0]  rest;

	assign numg = {diff_s2, 8'b0} - 41'(diff_s2);
	assign rest = {1'b0, lpcp_pkg::Q_HUNDRED} - diff_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s3    <= n_s2[2][W-1] ? -n_s2[0] : n_s2[0];
			n1_s3    <= n_s2[2][W-1] ? -n_s2[1] : n_s2[1];
			den_s3   <= n_s2[2][W-1] ? W'(-n_s2[2]) : W'(n_s2[2]);
			zero_s3  <= (n_s2[2] == '0);
			range_s3 <= !((mn_s2 < d2_s2) && (d2_s2 < mx_s2));
			fov_s3   <= fov_s2;
			numg_s3  <= numg;
			gsat_s3  <= (numg >= {1'b0, lpcp_pkg::Q_HUNDRED, 8'b0});
			numr_s3  <= (diff_s2 < {1'b0, lpcp_pkg::Q_HUNDRED}) ?
				({rest, 8'b0} - 41'(rest)) : '0;
		end
	end

	// Stage 4: image bounds, final verdict and color levels; results then
	// wait for the dividers in a side delay line.
	logic [63:0] lim_u, lim_v;
	logic        img_bad;
	lpcp_pkg::verdict_t verdict;

	assign lim_u   = {13'b0, den_s3} * 64'(lpcp_pkg::IMAGE_WIDTH);
	assign lim_v   = {13'b0, den_s3} * 64'(lpcp_pkg::IMAGE_HEIGHT);
	assign img_bad = zero_s3 || n0_s3[W-1] || n1_s3[W-1]
		|| ({13'b0, n0_s3} >= lim_u) || ({13'b0, n1_s3} >= lim_v);

	always_comb begin
		if (fov_s3) begin
			verdict = lpcp_pkg::V_FOV;
		end else if (range_s3) begin
			verdict = lpcp_pkg::V_RANGE;
		end else if (img_bad) begin
			verdict = lpcp_pkg::V_IMAGE;
		end else begin
			verdict = lpcp_pkg::V_KEPT;
		end
	end

	// Both numerators are below 256 * 2^16 * 100 whenever their level is used,
	// so dividing the upper bits by 100 gives the exact floor.
	logic [27:0]                  g_prod, r_prod;
	logic [lpcp_pkg::LEVEL_W-1:0] green_lvl, red_lvl;

	assign g_prod    = 28'(numg_s3[30:16]) * 28'(lpcp_pkg::RECIP_100);
	assign r_prod    = 28'(numr_s3[30:16]) * 28'(lpcp_pkg::RECIP_100);
	assign green_lvl = gsat_s3 ? {lpcp_pkg::LEVEL_W{1'b1}} :
		g_prod[lpcp_pkg::RECIP_SHIFT +: lpcp_pkg::LEVEL_W];
	assign red_lvl   = r_prod[lpcp_pkg::RECIP_SHIFT +: lpcp_pkg::LEVEL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= '0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= {vld_s4[QN-2:0], vld_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4[0].verdict <= verdict;
			side_s4[0].green   <= green_lvl;
			side_s4[0].red     <= red_lvl;
			for (int i = 1; i < QN; i++) begin
				side_s4[i] <= side_s4[i-1];
			end
		end
	end

	// Divider pipelines: column and row.
	logic [QN-1:0] quo_u, quo_v;

	lpcp_div u_div_col (
		.clk (clk),
		.en  (en),
		.num (n0_s3),
		.den (den_s3),
		.quo (quo_u)
	);

	lpcp_div u_div_row (
		.clk (clk),
		.en  (en),
		.num (n1_s3),
		.den (den_s3),
		.quo (quo_v)
	);

	// Output: last stage registers feed the master side; tdata fields are zeroed unless the point is kept.
	logic                             kept;
	logic [lpcp_pkg::COL_W-1:0]       pix_col;
	logic [lpcp_pkg::ROW_W-1:0]       pix_row;
	logic [lpcp_pkg::LEVEL_W-1:0]     green, red;

	assign kept    = (side_s4[QN-1].verdict == lpcp_pkg::V_KEPT);
	assign pix_col = kept ? quo_u[lpcp_pkg::COL_W-1:0] : '0;
	assign pix_row = kept ? quo_v[lpcp_pkg::ROW_W-1:0] : '0;
	assign green   = kept ? side_s4[QN-1].green : '0;
	assign red     = kept ? side_s4[QN-1].red : '0;

	assign m_axis_tvalid = vld_s4[QN-1];
	assign m_axis_tuser  = side_s4[QN-1].verdict;
	assign m_axis_tdata  = {5'b0, red, green, pix_row, pix_col};

	// A kept point always lands inside the image.
	a_col_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && kept) |->
		((lpcp_pkg::IMAGE_WIDTH > 1024) || (32'(pix_col) < lpcp_pkg::IMAGE_WIDTH)))
		else $error("kept point column outside the image");

	a_row_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && kept) |->
		((lpcp_pkg::IMAGE_HEIGHT > 512) || (32'(pix_row) < lpcp_pkg::IMAGE_HEIGHT)))
		else $error("kept point row outside the image");

	// A held pipeline keeps its early valid bits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s1) && $stable(vld_s3)))
		else $error("pipeline moved while stalled");

endmodule

[dv/tb_lidar_point_camera_projection.sv]
// Testbench for the lidar point camera projection block: predicted verdicts and pixels per point.
`timescale 1ns / 1ps

module tb_lidar_point_camera_projection;

	// Pipeline depth given by the block, and the watchdog limit on cycles without a transfer.
	localparam int LATENCY     = 3 + lpcp_pkg::QS;
	localparam int STALL_LIMIT = 5000;

	// One predicted result: the verdict from tuser and the tdata fields.
	typedef struct packed {
		lpcp_pkg::verdict_t             verdict;
		logic [lpcp_pkg::COL_W-1:0]     column;
		logic [lpcp_pkg::ROW_W-1:0]     row;
		logic [lpcp_pkg::LEVEL_W-1:0]   green;
		logic [lpcp_pkg::LEVEL_W-1:0]   red;
	} pixel_t;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [95:0]   s_axis_tdata;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [39:0]   m_axis_tdata;
	logic [1:0]    m_axis_tuser;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [lpcp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0]   cfg_data;

	// Shadow copy of the register file, written as each cfg transfer lands.
	logic [63:0] shadow_regs [8];
	pixel_t      pending_pixels [$];

	bit      idling_on;
	int      mismatches = 0;
	int      verdict_count [4];
	int      stall_left = 0;
	int      quiet_cycles = 0;

	lidar_point_camera_projection dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Matrix coefficient r,c as a signed Q15.16 value widened to 64 bits.
	function automatic longint coef_at(int r, int c);
		logic [63:0] w;
		w = shadow_regs[r * 2 + c / 2];
		if (c % 2)
			return longint'(signed'(w[63:32]));
		return longint'(signed'(w[31:0]));
	endfunction

	// One row of the projection; an arithmetic shift of a signed product is a floor.
	function automatic longint project_row(int r, longint x, longint y, longint z);
		return ((coef_at(r, 0) * x) >>> 16) + ((coef_at(r, 1) * y) >>> 16)
			+ ((coef_at(r, 2) * z) >>> 16) + coef_at(r, 3);
	endfunction

	// Exact test of 0 <= n/d < lim on the rational quotient; q gets the truncated value.
	function automatic bit within_image(longint n, longint d, longint lim, output longint q);
		q = 0;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		if (n < 0 || n >= lim * d)
			return 1'b0;
		q = n / d;
		return 1'b1;
	endfunction

	function automatic pixel_t predict_pixel(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		pixel_t  res;
		longint  x, y, z, ay, n0, n1, n2, diff, col, row, g, r;
		bit [63:0] ux, uy, uz, dist_sq, lo_sq, hi_sq;
		res = '0;
		x = longint'(signed'(px));
		y = longint'(signed'(py));
		z = longint'(signed'(pz));
		ay = (y < 0) ? -y : y;
		if (x < ay) begin
			res.verdict = lpcp_pkg::V_FOV;
			return res;
		end
		// Squares wrap at 64 bits exactly as the unsigned distance check does.
		ux = (x < 0) ? -x : x;
		uy = ay;
		uz = (z < 0) ? -z : z;
		dist_sq = ux * ux + uy * uy + uz * uz;
		lo_sq = shadow_regs[lpcp_pkg::REG_MIN_RANGE] * shadow_regs[lpcp_pkg::REG_MIN_RANGE];
		hi_sq = shadow_regs[lpcp_pkg::REG_MAX_RANGE] * shadow_regs[lpcp_pkg::REG_MAX_RANGE];
		if (!(lo_sq < dist_sq && dist_sq < hi_sq)) begin
			res.verdict = lpcp_pkg::V_RANGE;
			return res;
		end
		n0 = project_row(0, x, y, z);
		n1 = project_row(1, x, y, z);
		n2 = project_row(2, x, y, z);
		if (n2 == 0 || !within_image(n0, n2, lpcp_pkg::IMAGE_WIDTH, col)
				|| !within_image(n1, n2, lpcp_pkg::IMAGE_HEIGHT, row)) begin
			res.verdict = lpcp_pkg::V_IMAGE;
			return res;
		end
		diff = x - longint'(lpcp_pkg::Q_HUNDRED);
		if (diff < 0)
			diff = -diff;
		g = 255 * diff / longint'(lpcp_pkg::Q_HUNDRED);
		if (g > 255)
			g = 255;
		r = 0;
		if (diff < longint'(lpcp_pkg::Q_HUNDRED))
			r = 255 * (longint'(lpcp_pkg::Q_HUNDRED) - diff) / longint'(lpcp_pkg::Q_HUNDRED);
		if (r > 255)
			r = 255;
		res.verdict = lpcp_pkg::V_KEPT;
		res.column  = col[lpcp_pkg::COL_W-1:0];
		res.row     = row[lpcp_pkg::ROW_W-1:0];
		res.green   = g[lpcp_pkg::LEVEL_W-1:0];
		res.red     = r[lpcp_pkg::LEVEL_W-1:0];
		return res;
	endfunction

	// Sends one point; tvalid stays high between back-to-back points and only
	// drops when the sender decides to idle.
	task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pz, py, px};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_pixels.push_back(predict_pixel(px, py, pz));
	endtask

	// Waits until every predicted result has come back and the pipeline is empty.
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		cfg_valid     <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Register write; the shadow copy follows the block's handling of each index.
	task automatic write_reg(logic [lpcp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx <= lpcp_pkg::REG_ROW2_COLS23)
			shadow_regs[idx] = value;
		else if (idx <= lpcp_pkg::REG_MAX_RANGE)
			shadow_regs[idx] = {32'd0, value[31:0]};
	endtask

	// Drains the pipeline, writes a full matrix and both bounds, then releases the channel.
	task automatic load_config(logic [31:0] m [12], logic [31:0] lo, logic [31:0] hi);
		drain_pipeline();
		write_reg(lpcp_pkg::REG_ROW0_COLS01, {m[1], m[0]});
		write_reg(lpcp_pkg::REG_ROW0_COLS23, {m[3], m[2]});
		write_reg(lpcp_pkg::REG_ROW1_COLS01, {m[5], m[4]});
		write_reg(lpcp_pkg::REG_ROW1_COLS23, {m[7], m[6]});
		write_reg(lpcp_pkg::REG_ROW2_COLS01, {m[9], m[8]});
		write_reg(lpcp_pkg::REG_ROW2_COLS23, {m[11], m[10]});
		write_reg(lpcp_pkg::REG_MIN_RANGE, {$urandom(), lo});
		write_reg(lpcp_pkg::REG_MAX_RANGE, {$urandom(), hi});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// A camera-like matrix: depth follows x, column from y, row from z, with
	// random focal lengths, small cross terms and random offsets.
	task automatic random_camera(output logic [31:0] m [12]);
		int fx, fy;
		fx = $urandom_range(100 << 16, 800 << 16);
		fy = $urandom_range(100 << 16, 800 << 16);
		m[0]  = 32'(($urandom_range(200, 440)) << 16) + $urandom_range(0, 65535);
		m[1]  = -fx;
		m[2]  = 32'($signed($urandom_range(0, 8000)) - 4000);
		m[3]  = 32'($signed($urandom_range(0, 2000000)) - 1000000);
		m[4]  = 32'(($urandom_range(140, 340)) << 16) + $urandom_range(0, 65535);
		m[5]  = 32'($signed($urandom_range(0, 8000)) - 4000);
		m[6]  = -fy;
		m[7]  = 32'($signed($urandom_range(0, 2000000)) - 1000000);
		m[8]  = 32'(65536 + $signed($urandom_range(0, 2000)) - 1000);
		m[9]  = 32'($signed($urandom_range(0, 2000)) - 1000);
		m[10] = 32'($signed($urandom_range(0, 2000)) - 1000);
		m[11] = 32'($signed($urandom_range(0, 200000)) - 100000);
	endtask

	// A point that usually clears field of view and range: forward up to 150 m,
	// lateral and vertical inside the camera cone.
	task automatic send_scene_point();
		int x, y, z;
		x = $urandom_range(1, 150 << 16);
		y = $signed($urandom_range(0, 2 * (x / 5) * 4)) - (x / 5) * 4;
		z = $signed($urandom_range(0, 2 * (x / 5) * 3)) - (x / 5) * 3;
		send_point(x, y, z);
	endtask

	// Reset values: a zero matrix gives zero depth, so nothing is kept.
	task automatic test_reset_defaults();
		send_point(32'd0, 32'd0, 32'd0);
		send_point(32'd65536, 32'd0, 32'd0);
		send_point(32'd100 << 16, 32'hFFFF_0000, 32'd12345);
		send_point(32'd201 << 16, 32'd0, 32'd0);
		send_point(32'd0, 32'd1, 32'd0);
	endtask

	// Directed corners: field of view edge, origin, exact 100 m, range edges,
	// field extremes and writes to unknown indexes.
	task automatic test_directed_corners();
		logic [31:0] m [12];
		random_camera(m);
		load_config(m, 32'd65536, 32'd13107200);
		drain_pipeline();
		write_reg(4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(4'd15, 64'h0123_4567_89AB_CDEF);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_point(32'd0, 32'd0, 32'd0);
		send_point(32'd10 << 16, 32'd10 << 16, 32'd0);
		send_point(32'd10 << 16, -(32'd10 << 16), 32'd0);
		send_point(32'd10 << 16, (32'd10 << 16) + 1, 32'd0);
		send_point(32'hFFFF_FFFF, 32'd0, 32'd0);
		send_point(32'd100 << 16, 32'd0, 32'd0);
		send_point(32'd50 << 16, 32'd0, 32'd0);
		send_point(32'd150 << 16, 32'd0, 32'd0);
		send_point(32'd1 << 16, 32'd0, 32'd0);
		send_point(32'd200 << 16, 32'd0, 32'd0);
		send_point(32'h7FFF_FFFF, 32'd0, 32'd0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'd20 << 16, 32'd19 << 16, 32'd0);
		send_point(32'd20 << 16, 32'd0, 32'd15 << 16);
	endtask

	// Extreme settings: open range with all-ones or max/min coefficients, then empty range.
	task automatic test_config_extremes();
		logic [31:0] m [12];
		foreach (m[i])
			m[i] = 32'hFFFF_FFFF;
		load_config(m, 32'd0, 32'hFFFF_FFFF);
		repeat (4) send_scene_point();
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		foreach (m[i])
			m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		load_config(m, 32'd0, 32'hFFFF_FFFF);
		repeat (4) send_scene_point();
		random_camera(m);
		load_config(m, 32'hFFFF_FFFF, 32'd0);
		repeat (4) send_scene_point();
	endtask

	// Random phases, each with its own matrix and bounds; most points are
	// inside the camera cone, the rest are raw 96-bit noise.
	task automatic test_random_points(int phases, int per_phase);
		logic [31:0] m [12];
		logic [31:0] lo, hi;
		for (int ph = 0; ph < phases; ph++) begin
			random_camera(m);
			lo = $urandom_range(0, 20 << 16);
			hi = $urandom_range(50 << 16, 300 << 16);
			load_config(m, lo, hi);
			for (int n = 0; n < per_phase; n++) begin
				if ($urandom_range(0, 4) == 0)
					send_point($urandom(), $urandom(), $urandom());
				else
					send_scene_point();
			end
		end
	endtask

	// Result checking and receiver back-pressure share one process so that
	// m_axis_tready gets a single assignment per edge.
	always @(posedge clk) begin
		pixel_t seen;
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.verdict = lpcp_pkg::verdict_t'(m_axis_tuser);
			seen.column  = m_axis_tdata[9:0];
			seen.row     = m_axis_tdata[18:10];
			seen.green   = m_axis_tdata[26:19];
			seen.red     = m_axis_tdata[34:27];
			if (pending_pixels.size() == 0) begin
				$display("%0t: result with nothing expected: tuser %0d tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				verdict_count[want.verdict]++;
				if (seen.verdict !== want.verdict) begin
					$display("%0t: verdict expected %0d actual %0d",
						$time, want.verdict, m_axis_tuser);
					mismatches++;
				end
				if (seen.column !== want.column) begin
					$display("%0t: pixel_column expected %0d actual %0d",
						$time, want.column, seen.column);
					mismatches++;
				end
				if (seen.row !== want.row) begin
					$display("%0t: pixel_row expected %0d actual %0d",
						$time, want.row, seen.row);
					mismatches++;
				end
				if (seen.green !== want.green) begin
					$display("%0t: green_level expected %0d actual %0d",
						$time, want.green, seen.green);
					mismatches++;
				end
				if (seen.red !== want.red) begin
					$display("%0t: red_level expected %0d actual %0d",
						$time, want.red, seen.red);
					mismatches++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog: a long run of cycles without any transfer means the block hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		idling_on     = 1'b1;
		for (int i = 0; i < 6; i++)
			shadow_regs[i] = '0;
		shadow_regs[lpcp_pkg::REG_MIN_RANGE] = {32'd0, lpcp_pkg::MIN_RANGE_RST};
		shadow_regs[lpcp_pkg::REG_MAX_RANGE] = {32'd0, lpcp_pkg::MAX_RANGE_RST};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_corners();
		test_config_extremes();
		test_random_points(14, 120);
		// Last part runs at full rate with no idling on either side.
		drain_pipeline();
		idling_on = 1'b0;
		test_random_points(2, 100);
		drain_pipeline();

		$display("Covered: %0d kept, %0d outside view, %0d outside range, %0d outside image",
			verdict_count[lpcp_pkg::V_KEPT], verdict_count[lpcp_pkg::V_FOV],
			verdict_count[lpcp_pkg::V_RANGE], verdict_count[lpcp_pkg::V_IMAGE]);
		$display("Reset defaults, directed corners, extreme settings and sixteen random cameras.");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
design/lpcp_pkg.sv
design/lpcp_div.sv
design/lidar_point_camera_projection.sv
dv/tb_lidar_point_camera_projection.sv
